[hw/rtl/adjue_pkg.sv]
// ----------------------------------------------------------------------------
// adjue_pkg
// Shared types and constants for the deduplicating adjacency table.
// ----------------------------------------------------------------------------
`default_nettype none

package adjue_pkg;

    localparam int NODE_W      = 10;
    localparam int SLOT_W      = 3;
    localparam int DEG_OUT_W   = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef enum logic [3:0]
    {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_WRB   = 4'b1000
    } state_t;

    // outcome of one row update, handed from the compare logic to the sequencer
    typedef struct packed
    {
        logic                  wr_a;
        logic                  wr_b;
        logic                  added_forward;
        logic                  added_reverse;
        logic [DEG_OUT_W-1:0]  degree_a;
        logic [DEG_OUT_W-1:0]  degree_b;
        logic [NODE_W-1:0]     read_value;
        logic                  read_valid;
        err_t                  error;
    } upd_t;

endpackage

`default_nettype wire

[hw/rtl/adjue_ram.sv]
// ----------------------------------------------------------------------------
// adjue_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module adjue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr0,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr1,
    output logic      [WIDTH-1:0]                          rdata0,
    output logic      [WIDTH-1:0]                          rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/adjue_row_update.sv]
// ----------------------------------------------------------------------------
// adjue_row_update
// Compares both endpoint rows in parallel, builds the appended rows and the
// result fields for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module adjue_row_update #(
    parameter int NODES          = 1024,
    parameter int MAX_NEIGHBOURS = 8
) (
    input  wire adjue_pkg::func_t                                   func,
    input  wire logic [adjue_pkg::NODE_W-1:0]                       node_a,
    input  wire logic [adjue_pkg::NODE_W-1:0]                       node_b,
    input  wire logic [adjue_pkg::SLOT_W-1:0]                       slot,
    input  wire logic [MAX_NEIGHBOURS*adjue_pkg::NODE_W
                       + $clog2(MAX_NEIGHBOURS+1)-1:0]              row_a,
    input  wire logic [MAX_NEIGHBOURS*adjue_pkg::NODE_W
                       + $clog2(MAX_NEIGHBOURS+1)-1:0]              row_b,
    output logic      [MAX_NEIGHBOURS*adjue_pkg::NODE_W
                       + $clog2(MAX_NEIGHBOURS+1)-1:0]              row_a_new,
    output logic      [MAX_NEIGHBOURS*adjue_pkg::NODE_W
                       + $clog2(MAX_NEIGHBOURS+1)-1:0]              row_b_new,
    output adjue_pkg::upd_t                                         upd
);

    localparam int NW    = adjue_pkg::NODE_W;
    localparam int DW    = $clog2(MAX_NEIGHBOURS + 1);
    localparam int LW    = MAX_NEIGHBOURS * NW;
    localparam int ROW_W = LW + DW;
    localparam logic [16:0] NODES_L = 17'(NODES);

    logic          a_ok;
    logic          b_ok;
    logic          self_loop;
    logic [DW-1:0] deg_a;
    logic [DW-1:0] deg_b;
    logic [DW-1:0] deg_a_new;
    logic [DW-1:0] deg_b_new;
    logic          has_f;
    logic          has_r;
    logic          need_f;
    logic          need_r;
    logic          full;
    logic          do_f;
    logic          do_r;
    logic [NW-1:0] rval;
    logic          rvalid;

    assign a_ok      = {7'b0, node_a} < NODES_L;
    assign b_ok      = {7'b0, node_b} < NODES_L;
    assign self_loop = node_a == node_b;
    assign deg_a     = row_a[ROW_W-1 -: DW];
    assign deg_b     = row_b[ROW_W-1 -: DW];

    // membership search over the valid part of each row
    always_comb
    begin
        has_f = 1'b0;
        has_r = 1'b0;
        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            if (i < 32'(deg_a) && row_a[i*NW +: NW] == node_b)
            begin
                has_f = 1'b1;
            end
            if (i < 32'(deg_b) && row_b[i*NW +: NW] == node_a)
            begin
                has_r = 1'b1;
            end
        end
    end

    assign need_f = !has_f;
    assign need_r = !self_loop && !has_r;
    assign full   = (need_f && 32'(deg_a) >= 32'(MAX_NEIGHBOURS))
                 || (need_r && 32'(deg_b) >= 32'(MAX_NEIGHBOURS));
    assign do_f   = (func == adjue_pkg::FUNC_INSERT) && a_ok && b_ok && !full && need_f;
    assign do_r   = (func == adjue_pkg::FUNC_INSERT) && a_ok && b_ok && !full && need_r;

    assign deg_a_new = deg_a + DW'(do_f);
    assign deg_b_new = self_loop ? deg_a_new : deg_b + DW'(do_r);

    // append at the slot just past the current degree
    always_comb
    begin
        row_a_new = row_a;
        row_b_new = row_b;
        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            if (32'(deg_a) == i)
            begin
                row_a_new[i*NW +: NW] = node_b;
            end
            if (32'(deg_b) == i)
            begin
                row_b_new[i*NW +: NW] = node_a;
            end
        end
        row_a_new[ROW_W-1 -: DW] = deg_a_new;
        row_b_new[ROW_W-1 -: DW] = deg_b_new;
    end

    always_comb
    begin
        rval   = '0;
        rvalid = a_ok && (32'(slot) < 32'(deg_a)) && (32'(slot) < 32'(MAX_NEIGHBOURS));
        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            if (rvalid && 32'(slot) == i)
            begin
                rval = row_a[i*NW +: NW];
            end
        end
    end

    always_comb
    begin
        upd               = '0;
        upd.wr_a          = do_f;
        upd.wr_b          = do_r;
        upd.added_forward = do_f;
        upd.added_reverse = do_r;
        upd.error         = adjue_pkg::ERR_OK;
        if (func == adjue_pkg::FUNC_INSERT)
        begin
            if (!a_ok || !b_ok)
            begin
                upd.error = adjue_pkg::ERR_RANGE;
            end
            else if (full)
            begin
                upd.error = adjue_pkg::ERR_FULL;
            end
            upd.degree_a = a_ok ? adjue_pkg::DEG_OUT_W'(deg_a_new) : '0;
            upd.degree_b = b_ok ? adjue_pkg::DEG_OUT_W'(deg_b_new) : '0;
        end
        else
        begin
            if (!a_ok)
            begin
                upd.error = adjue_pkg::ERR_RANGE;
            end
            upd.degree_a   = a_ok ? adjue_pkg::DEG_OUT_W'(deg_a) : '0;
            upd.read_value = rval;
            upd.read_valid = rvalid;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/adjacency_unique_edge_insert.sv]
// ----------------------------------------------------------------------------
// adjacency_unique_edge_insert
// Bounded, deduplicated neighbour table of an undirected graph.
// ----------------------------------------------------------------------------
// Each node owns one memory row holding its neighbour list and its degree.
// An item reads the rows of both endpoints together through the two read
// ports, compares them in parallel in ST_CALC and, once the output is free,
// writes the updated row of node_a back; the row of node_b is written in
// ST_WRB when the reverse direction was added. Every item passes ST_IDLE and
// ST_CALC, an insert that adds the reverse direction also ST_WRB; the single
// write port of the row memory sets that path. After reset the block zeroes
// every row in ST_CLEAR and takes no item during that pass. The result
// register lets a new item enter while the previous result waits.
`default_nettype none

module adjacency_unique_edge_insert #(
    parameter int NODES          = 1024,
    parameter int MAX_NEIGHBOURS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // s_tdata: node_a[9:0], node_b[19:10], slot[22:20], zero pad
    input  wire logic [adjue_pkg::IN_TDATA_W-1:0]    s_tdata,
    // s_tuser: func
    input  wire logic                                s_tuser,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // m_tdata: added_forward[0], added_reverse[1], degree_a[5:2],
    // degree_b[9:6], read_value[19:10], read_valid[20], error[22:21], zero pad
    output logic      [adjue_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready
);

    localparam int NW    = adjue_pkg::NODE_W;
    localparam int DW    = $clog2(MAX_NEIGHBOURS + 1);
    localparam int ROW_W = MAX_NEIGHBOURS * NW + DW;
    localparam int AW    = NODES > 1 ? $clog2(NODES) : 1;

    adjue_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                 clr_cnt_reg, clr_cnt_next;
    adjue_pkg::func_t              func_reg;
    logic [NW-1:0]                 node_a_reg;
    logic [NW-1:0]                 node_b_reg;
    logic [adjue_pkg::SLOT_W-1:0]  slot_reg;
    logic [ROW_W-1:0]              row_b_wr_reg;
    logic [adjue_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    logic                          accept;
    logic                          out_free;
    logic                          finish;
    logic [NW-1:0]                 in_node_a;
    logic [NW-1:0]                 in_node_b;
    logic [AW-1:0]                 rd_addr_a;
    logic [AW-1:0]                 rd_addr_b;
    logic [AW-1:0]                 addr_a_reg_idx;
    logic [AW-1:0]                 addr_b_reg_idx;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [ROW_W-1:0]              ram_wdata;
    logic [ROW_W-1:0]              row_a;
    logic [ROW_W-1:0]              row_b;
    logic [ROW_W-1:0]              row_a_new;
    logic [ROW_W-1:0]              row_b_new;
    adjue_pkg::upd_t               upd;

    assign in_node_a = s_tdata[NW-1:0];
    assign in_node_b = s_tdata[2*NW-1:NW];

    // out-of-range nodes still address some row; the result ignores it
    assign rd_addr_a      = AW'(32'(in_node_a));
    assign rd_addr_b      = AW'(32'(in_node_b));
    assign addr_a_reg_idx = AW'(32'(node_a_reg));
    assign addr_b_reg_idx = AW'(32'(node_b_reg));

    assign s_tready = state_reg == adjue_pkg::ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == adjue_pkg::ST_CALC) && out_free;

    adjue_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODES)
    ) u_rows (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (accept),
        .raddr0 (rd_addr_a),
        .raddr1 (rd_addr_b),
        .rdata0 (row_a),
        .rdata1 (row_b)
    );

    adjue_row_update #(
        .NODES          (NODES),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
    ) u_update (
        .func      (func_reg),
        .node_a    (node_a_reg),
        .node_b    (node_b_reg),
        .slot      (slot_reg),
        .row_a     (row_a),
        .row_b     (row_b),
        .row_a_new (row_a_new),
        .row_b_new (row_b_new),
        .upd       (upd)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_a_reg_idx;
        ram_wdata = row_a_new;
        unique case (state_reg)
            adjue_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            adjue_pkg::ST_CALC:
            begin
                ram_we = finish && upd.wr_a;
            end
            adjue_pkg::ST_WRB:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_b_reg_idx;
                ram_wdata = row_b_wr_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            adjue_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(NODES - 1))
                begin
                    state_next = adjue_pkg::ST_IDLE;
                end
            end
            adjue_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = adjue_pkg::ST_CALC;
                end
            end
            adjue_pkg::ST_CALC:
            begin
                if (finish)
                begin
                    state_next = upd.wr_b ? adjue_pkg::ST_WRB : adjue_pkg::ST_IDLE;
                end
            end
            adjue_pkg::ST_WRB:
            begin
                state_next = adjue_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = adjue_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (finish)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, upd.error, upd.read_valid, upd.read_value,
                             upd.degree_b, upd.degree_a,
                             upd.added_reverse, upd.added_forward};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= adjue_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            func_reg   <= adjue_pkg::func_t'(s_tuser);
            node_a_reg <= in_node_a;
            node_b_reg <= in_node_b;
            slot_reg   <= s_tdata[2*NW+adjue_pkg::SLOT_W-1:2*NW];
        end
        if (finish)
        begin
            row_b_wr_reg <= row_b_new;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

[sim/tb_adjacency_unique_edge_insert.sv]
// ----------------------------------------------------------------------------
// tb_adjacency_unique_edge_insert
// Self-checking bench for the deduplicated neighbour table: a scoreboard keeps
// its own copy of every list and degree, predicts one result per item and
// checks each output item by field, with random stalls on both sides or none.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adjacency_unique_edge_insert;

    import adjue_pkg::*;

    localparam int NODE_COUNT   = 1024;
    localparam int MAX_NBR      = 8;
    localparam int HOT_NODES    = 12;
    localparam int PHASE_ITEMS  = 260;
    localparam int MAX_PRINTED  = 40;
    localparam int CYCLE_LIMIT  = 300000;

    // one output item, lowest field at the bottom
    typedef struct packed
    {
        logic                  pad;
        err_t                  error;
        logic                  read_valid;
        logic [NODE_W-1:0]     read_value;
        logic [DEG_OUT_W-1:0]  degree_b;
        logic [DEG_OUT_W-1:0]  degree_a;
        logic                  added_reverse;
        logic                  added_forward;
    } edge_result_t;

    class adjacency_scoreboard;
        logic [NODE_W-1:0] nbr_list [NODE_COUNT][MAX_NBR];
        int unsigned       degree [NODE_COUNT];
        edge_result_t      expected_q[$];
        int unsigned       mismatches;
        int unsigned       results_seen;
        int unsigned       inserts;
        int unsigned       reads;
        int unsigned       entries_added;
        int unsigned       duplicates;
        int unsigned       full_drops;
        int unsigned       valid_reads;

        function bit listed(int unsigned node, logic [NODE_W-1:0] who);
            for (int i = 0; i < degree[node] && i < MAX_NBR; i++)
                if (nbr_list[node][i] == who)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void append(int unsigned node, logic [NODE_W-1:0] who);
            nbr_list[node][degree[node]] = who;
            degree[node]++;
            entries_added++;
        endfunction

        // node fields are NODE_W bits wide, so with NODES at 1024 an
        // out-of-range endpoint cannot be presented
        function void note(func_t f, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                           logic [SLOT_W-1:0] slot);
            edge_result_t res;
            bit need_fwd;
            bit need_rev;
            res = '0;
            if (f == FUNC_INSERT)
            begin
                inserts++;
                need_fwd = !listed(a, b);
                need_rev = (a != b) && !listed(b, a);
                if ((need_fwd && degree[a] >= MAX_NBR) || (need_rev && degree[b] >= MAX_NBR))
                begin
                    res.error = ERR_FULL;
                    full_drops++;
                end
                else
                begin
                    if (need_fwd)
                    begin
                        append(a, b);
                        res.added_forward = 1'b1;
                    end
                    if (need_rev)
                    begin
                        append(b, a);
                        res.added_reverse = 1'b1;
                    end
                    if (!need_fwd && !need_rev)
                        duplicates++;
                end
                res.degree_a = DEG_OUT_W'(degree[a]);
                res.degree_b = DEG_OUT_W'(degree[b]);
            end
            else
            begin
                reads++;
                res.degree_a = DEG_OUT_W'(degree[a]);
                if (slot < degree[a])
                begin
                    res.read_valid = 1'b1;
                    res.read_value = nbr_list[a][slot];
                    valid_reads++;
                end
            end
            expected_q.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("tb: mismatch on %s, got %0h expected %0h", what, got, want);
        endtask

        task check(logic [OUT_TDATA_W-1:0] data);
            edge_result_t got;
            edge_result_t want;
            got = data;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report("unexpected result item", 32'(data), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.added_forward !== want.added_forward)
                report("added_forward", 32'(got.added_forward), 32'(want.added_forward));
            if (got.added_reverse !== want.added_reverse)
                report("added_reverse", 32'(got.added_reverse), 32'(want.added_reverse));
            if (got.degree_a !== want.degree_a)
                report("degree_a", 32'(got.degree_a), 32'(want.degree_a));
            if (got.degree_b !== want.degree_b)
                report("degree_b", 32'(got.degree_b), 32'(want.degree_b));
            if (got.read_value !== want.read_value)
                report("read_value", 32'(got.read_value), 32'(want.read_value));
            if (got.read_valid !== want.read_valid)
                report("read_valid", 32'(got.read_valid), 32'(want.read_valid));
            if (got.error !== want.error)
                report("error", 32'(got.error), 32'(want.error));
            if (got.pad !== 1'b0)
                report("pad bit", 32'(got.pad), 0);
        endtask

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic [IN_TDATA_W-1:0]    s_tdata  = '0;
    logic                     s_tuser  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;

    int unsigned              send_idle_pct  = 0;
    int unsigned              recv_stall_pct = 0;
    int unsigned              cycles         = 0;
    int unsigned              hot_base       = 0;

    adjacency_scoreboard      sb = new;

    adjacency_unique_edge_insert dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tdata);

    // presents one item and returns at the edge where it is taken
    task send_item(func_t f, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                   logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, slot, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note(f, a, b, slot);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    function logic [NODE_W-1:0] hot_node();
        return NODE_W'(hot_base + $urandom_range(HOT_NODES - 1));
    endfunction

    task run_directed();
        send_item(FUNC_READ,   10'd0,    10'd1023, 3'd0);   // empty list
        send_item(FUNC_INSERT, 10'd0,    10'd1,    3'd7);
        send_item(FUNC_INSERT, 10'd0,    10'd1,    3'd0);   // duplicate
        send_item(FUNC_INSERT, 10'd1,    10'd0,    3'd0);   // duplicate, swapped
        send_item(FUNC_INSERT, 10'd5,    10'd5,    3'd0);   // self-loop
        send_item(FUNC_INSERT, 10'd5,    10'd5,    3'd7);
        send_item(FUNC_READ,   10'd5,    10'd0,    3'd0);
        send_item(FUNC_READ,   10'd0,    10'd0,    3'd1);   // slot past the degree
        for (int k = 1; k <= MAX_NBR; k++)
            send_item(FUNC_INSERT, 10'd1023, NODE_W'(k), SLOT_W'(k));
        send_item(FUNC_INSERT, 10'd1023, 10'd9,    3'd0);   // forward list full
        send_item(FUNC_INSERT, 10'd9,    10'd1023, 3'd0);   // reverse list full
        send_item(FUNC_INSERT, 10'd1023, 10'd4,    3'd0);   // present, list full
        send_item(FUNC_READ,   10'd1023, 10'd0,    3'd7);
        send_item(FUNC_INSERT, 10'd0,    10'd1023, 3'd0);
        send_item(FUNC_READ,   10'd1023, 10'd682,  3'd0);
    endtask

    // mostly edges among a small group of nodes so lists fill up and repeat
    task run_random(int unsigned count);
        int unsigned pick;
        hot_base = $urandom_range(NODE_COUNT - HOT_NODES);
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                send_item(func_t'($urandom_range(1)), NODE_W'($urandom),
                          NODE_W'($urandom), SLOT_W'($urandom));
            else if (pick < 65)
                send_item(FUNC_INSERT, hot_node(), hot_node(), SLOT_W'($urandom));
            else
                send_item(FUNC_READ, hot_node(), NODE_W'($urandom), SLOT_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 17;
        recv_stall_pct = 54;
        run_directed();
        drain();
        run_random(PHASE_ITEMS);
        drain();

        send_idle_pct  = 54;
        recv_stall_pct = 17;
        run_random(PHASE_ITEMS);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);
        s_tvalid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report("results never delivered", sb.outstanding(), 0);

        $display("tb: %0d inserts and %0d reads checked over %0d result items",
                 sb.inserts, sb.reads, sb.results_seen);
        $display("tb: %0d entries added, %0d duplicate edges, %0d dropped as full, %0d slot hits",
                 sb.entries_added, sb.duplicates, sb.full_drops, sb.valid_reads);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
